### hw/rtl/fssa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fssa_pkg
// Shared types, widths and helper functions of the sample splat accumulator.
// ----------------------------------------------------------------------------
package fssa_pkg;

  localparam int IN_W  = 136;  // 129 bits of fields, padded to bytes
  localparam int OUT_W = 160;
  localparam int MW    = 20;   // shared multiplier operand width
  localparam int CW    = 16;   // signed pixel coordinate width
  localparam int DW    = 15;   // tile origin numerator width

  localparam logic [1:0] OP_SPLAT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TABLE = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_BUCKET = 2'd1;
  localparam logic [1:0] REG_BOUNDS = 2'd2;
  localparam logic [1:0] REG_TILE   = 2'd3;

  typedef enum logic [17:0] {
    ST_CLEAR   = 18'h00001,
    ST_IDLE    = 18'h00002,
    ST_DIV     = 18'h00004,
    ST_DX      = 18'h00008,
    ST_DY      = 18'h00010,
    ST_D2      = 18'h00020,
    ST_KA      = 18'h00040,
    ST_KB      = 18'h00080,
    ST_KC      = 18'h00100,
    ST_TR      = 18'h00200,
    ST_CH      = 18'h00400,
    ST_CA      = 18'h00800,
    ST_WR      = 18'h01000,
    ST_NXT     = 18'h02000,
    ST_RD_WAIT = 18'h04000,
    ST_RD_OUT  = 18'h08000,
    ST_SPARE0  = 18'h10000,
    ST_SPARE1  = 18'h20000
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // floor((s - w) / 256)
  function automatic logic signed [CW-1:0] span_lo(input logic [21:0] s,
                                                   input logic [10:0] w);
    logic signed [22:0] t;
    t = $signed({1'b0, s}) - $signed({12'b0, w});
    return CW'(t >>> 8);
  endfunction

  // ceil((s + w) / 256)
  function automatic logic signed [CW-1:0] span_hi(input logic [21:0] s,
                                                   input logic [10:0] w);
    logic [23:0] t;
    t = {2'b0, s} + {13'b0, w} + 24'd255;
    return $signed(CW'(t >> 8));
  endfunction

  // floor((s - bounds * 256) / 256)
  function automatic logic signed [DW-1:0] org_num(input logic [21:0] s,
                                                   input logic [4:0] fb);
    logic signed [22:0] t;
    t = $signed({1'b0, s}) - $signed({5'b0, fb, 8'b0});
    return DW'(t >>> 8);
  endfunction

  // bucket * floor(m / bucket) from the remainder of |m| / bucket
  function automatic logic signed [CW-1:0] org_val(input logic signed [DW-1:0] m,
                                                   input logic [6:0] r,
                                                   input logic [6:0] b);
    logic signed [CW-1:0] me;
    me = CW'(m);
    if (b == 7'd0) return '0;
    if (!m[DW-1]) return me - $signed({9'b0, r});
    if (r == 7'd0) return me;
    return me + $signed({9'b0, r}) - $signed({9'b0, b});
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [25:0] v);
    logic [25:0] a;
    a = v[25] ? 26'(-v) : 26'(v);
    return a[MW-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/fssa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fssa_ram
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fssa_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/fssa_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fssa_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module fssa_mul #(
  parameter int W = 20
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic      [2*W-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

### hw/rtl/filtered_sample_splat_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// filtered_sample_splat_accumulator
// Splats filtered samples into a tile store; reads and clears tile entries.
// Splat: bitwise tile origin division for x then y, then for each footprint
//   pixel a tile check; a pixel inside the tile also gets a distance, a bitwise
//   table index search and four channel products, all on one shared multiplier.
// Read: returns and clears the entry once the output is free. Table write: on input.
// Reset: sync; a clearing pass over the store zeroes store/table.
// ----------------------------------------------------------------------------
module filtered_sample_splat_accumulator #(
  parameter int TABLE_ENTRIES = 64,
  parameter int TILE_EDGE     = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // op, sample_x, sample_y, red_in, green_in, blue_in, alpha_in, entry_index,
  // table_slot, table_word
  input  wire logic [fssa_pkg::IN_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // red_sum, green_sum, blue_sum, alpha_sum, weight_sum
  output logic [fssa_pkg::OUT_W-1:0]     m_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [10:0]               cfg_data
);
  import fssa_pkg::*;

  localparam int TW    = $clog2(TABLE_ENTRIES);
  localparam int BW    = $clog2(TW);
  localparam int DEPTH = TILE_EDGE * TILE_EDGE;
  localparam int SAW   = $clog2(DEPTH);

  state_t state;
  logic [SAW-1:0] cnt;
  logic [10:0] fw;
  logic [6:0]  bsz, ts;
  logic [4:0]  fb;
  logic [21:0] sx, sy;
  logic [15:0] rin, gin, bin;
  logic        ain;
  logic signed [DW-1:0] mx, my;
  logic        axis;
  logic [3:0]  dcnt;
  logic [6:0]  rem;
  logic signed [CW-1:0] ox, oy, x, y;
  logic [SAW-1:0] addr;
  logic [24:0] d2;
  logic [TW-1:0] k;
  logic [BW-1:0] bitp;
  logic [1:0]  c;
  logic [31:0] acc [4];
  logic        zero;
  logic [OUT_W-1:0] out_data;

  // input fields
  logic [1:0]  in_op;
  logic [11:0] in_entry;
  logic [5:0]  in_slot;
  logic [15:0] in_word;
  assign in_op    = s_tdata[1:0];
  assign in_entry = s_tdata[106:95];
  assign in_slot  = s_tdata[112:107];
  assign in_word  = s_tdata[128:113];

  logic acc_in;
  assign s_tready = (state == ST_IDLE);
  assign acc_in   = s_tvalid && s_tready;

  // tile origin divider step
  logic signed [DW-1:0] num;
  logic [DW-1:0] nmag;
  logic [7:0]  rsh;
  logic [6:0]  rnew;
  assign num  = axis ? my : mx;
  assign nmag = num[DW-1] ? DW'(-num) : DW'(num);
  assign rsh  = {rem, nmag[dcnt]};
  assign rnew = (rsh >= {1'b0, bsz}) ? 7'(rsh - {1'b0, bsz}) : rsh[6:0];

  logic signed [CW-1:0] x0, x1, y0, y1;
  assign x0 = span_lo(sx, fw);
  assign x1 = span_hi(sx, fw);
  assign y0 = span_lo(sy, fw);
  assign y1 = span_hi(sy, fw);

  // hit position in the tile
  logic signed [CW:0] tx, ty;
  logic in_tile;
  logic [14:0] idx;
  assign tx = (CW+1)'(x) - (CW+1)'(ox);
  assign ty = (CW+1)'(y) - (CW+1)'(oy);
  assign in_tile = !tx[CW] && !ty[CW] && (tx < $signed({10'b0, ts}))
                   && (ty < $signed({10'b0, ts}));
  assign idx = 15'(ty[6:0]) * 15'(ts) + {8'b0, tx[6:0]};

  logic [MW-1:0] dxm, dym;
  assign dxm = mag((26'(x) <<< 8) + 26'sd128 - $signed({4'b0, sx}));
  assign dym = mag((26'(y) <<< 8) + 26'sd128 - $signed({4'b0, sy}));

  logic [TW-1:0] cand;
  logic cand_ok;
  assign cand    = k | (TW'(1) << bitp);
  assign cand_ok = 32'(cand) <= 32'(TABLE_ENTRIES - 1);

  // shared multiplier
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] p;
  logic [15:0] trd;
  logic [15:0] chv;

  always_comb begin
    case (c)
      2'd0:    chv = rin;
      2'd1:    chv = gin;
      2'd2:    chv = bin;
      default: chv = ain ? 16'd256 : 16'd0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_DX: begin
        mul_a = dxm;
        mul_b = dxm;
      end
      ST_DY: begin
        mul_a = dym;
        mul_b = dym;
      end
      ST_KA: begin
        mul_a = MW'(cand);
        mul_b = MW'(fw);
      end
      ST_KB: begin
        mul_a = p[MW-1:0];
        mul_b = p[MW-1:0];
      end
      ST_CH: begin
        mul_a = MW'(trd);
        mul_b = MW'(chv);
      end
      default: ;
    endcase
  end

  fssa_mul #(.W(MW)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  // table memory
  logic          t_we;
  logic [TW-1:0] t_waddr;
  logic [15:0]   t_wdata;
  always_comb begin
    t_we    = 1'b0;
    t_waddr = TW'(in_slot);
    t_wdata = in_word;
    if (state == ST_CLEAR) begin
      t_we    = 32'(cnt) < 32'(TABLE_ENTRIES);
      t_waddr = TW'(cnt);
      t_wdata = '0;
    end else if (acc_in && in_op == OP_TABLE) begin
      t_we = 32'(in_slot) < 32'(TABLE_ENTRIES);
    end
  end

  fssa_ram #(.W(16), .D(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(k), .rdata(trd)
  );

  // tile store, red in the lowest word
  logic           s_we;
  logic [SAW-1:0] s_waddr;
  logic [159:0]   s_wdata;
  logic [159:0]   srd;
  always_comb begin
    s_we    = 1'b0;
    s_waddr = addr;
    s_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = cnt;
      end
      ST_WR: begin
        s_we    = 1'b1;
        s_wdata = {sat_add(srd[159:128], {16'b0, trd}), acc[3], acc[2], acc[1], acc[0]};
      end
      ST_RD_OUT: s_we = !m_tvalid && !zero;
      default: ;
    endcase
  end

  fssa_ram #(.W(160), .D(DEPTH)) u_store (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(addr), .rdata(srd)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fw  <= 11'd512;
      bsz <= 7'd56;
      fb  <= 5'd4;
      ts  <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  fw  <= cfg_data;
        REG_BUCKET: bsz <= cfg_data[6:0];
        REG_BOUNDS: fb  <= cfg_data[4:0];
        REG_TILE:   ts  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          cnt <= cnt + SAW'(1);
          if (cnt == SAW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc_in) begin
            case (in_op)
              OP_SPLAT: begin
                sx    <= s_tdata[23:2];
                sy    <= s_tdata[45:24];
                rin   <= s_tdata[61:46];
                gin   <= s_tdata[77:62];
                bin   <= s_tdata[93:78];
                ain   <= s_tdata[94];
                mx    <= org_num(s_tdata[23:2], fb);
                my    <= org_num(s_tdata[45:24], fb);
                axis  <= 1'b0;
                dcnt  <= 4'(DW - 1);
                rem   <= '0;
                state <= ST_DIV;
              end
              OP_READ: begin
                addr  <= SAW'(in_entry);
                zero  <= !(32'(in_entry) < 32'(DEPTH));
                state <= ST_RD_WAIT;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (dcnt == 4'd0) begin
            rem  <= '0;
            dcnt <= 4'(DW - 1);
            if (!axis) begin
              ox   <= org_val(mx, rnew, bsz);
              axis <= 1'b1;
            end else begin
              oy <= org_val(my, rnew, bsz);
              x  <= x0;
              y  <= y0;
              state <= (x0 < x1 && y0 < y1) ? ST_DX : ST_IDLE;
            end
          end else begin
            rem  <= rnew;
            dcnt <= dcnt - 4'd1;
          end
        end
        ST_DX: begin
          addr  <= SAW'(idx);
          state <= (in_tile && 32'(idx) < 32'(DEPTH)) ? ST_DY : ST_NXT;
        end
        ST_DY: begin
          d2    <= 25'(p);
          state <= ST_D2;
        end
        ST_D2: begin
          d2    <= d2 + 25'(p);
          k     <= '0;
          bitp  <= BW'(TW - 1);
          state <= ST_KA;
        end
        ST_KA: state <= ST_KB;
        ST_KB: state <= ST_KC;
        ST_KC: begin
          if (cand_ok && {1'b0, p} <= (41'(d2) << (2 * TW))) begin
            k <= cand;
          end
          bitp  <= bitp - BW'(1);
          state <= (bitp == '0) ? ST_TR : ST_KA;
        end
        ST_TR: begin
          c     <= 2'd0;
          state <= ST_CH;
        end
        ST_CH: state <= ST_CA;
        ST_CA: begin
          acc[c] <= sat_add(srd[32*c +: 32], {16'b0, p[31:16]});
          c      <= c + 2'd1;
          state  <= (c == 2'd3) ? ST_WR : ST_CH;
        end
        ST_WR: state <= ST_NXT;
        ST_NXT: begin
          if (x + CW'(1) < x1) begin
            x     <= x + CW'(1);
            state <= ST_DX;
          end else begin
            x <= x0;
            if (y + CW'(1) < y1) begin
              y     <= y + CW'(1);
              state <= ST_DX;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RD_WAIT: state <= ST_RD_OUT;
        ST_RD_OUT: begin
          if (!m_tvalid) begin
            out_data <= zero ? '0 : srd;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = out_data;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input taken during clearing pass");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_RD_OUT))
    else $error("result beat not from a read");

  a_store_write_state: assert property (@(posedge clk) disable iff (rst)
    s_we |-> (state == ST_CLEAR || state == ST_WR || state == ST_RD_OUT))
    else $error("unexpected store write");

endmodule
`default_nettype wire
